### hw/rtl/iqtr_pkg.sv
// Shared types and constants for the image quarter-turn rotator.
`default_nettype none

package iqtr_pkg;

  // Default geometry and pixel size
  localparam int IQTR_MAX_WIDTH  = 64;
  localparam int IQTR_MAX_HEIGHT = 64;
  localparam int IQTR_PIXEL_BITS = 32;

  // Fixed field widths of the ports
  localparam int IQTR_CFG_DATA_W = 7;
  localparam int IQTR_CFG_IDX_W  = 2;
  localparam int IQTR_DIM_FLD_W  = 7;
  localparam int IQTR_POS_FLD_W  = 6;
  localparam int IQTR_PIX_FLD_W  = 32;

  // Configuration register indexes
  typedef enum logic [IQTR_CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_QUARTER_TURNS = 2'd2,
    CFG_TURN_LEFT     = 2'd3
  } cfg_idx_t;

  // Item operation
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  // Effective clockwise rotation
  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_t;

  // Register reset values
  localparam logic [IQTR_CFG_DATA_W-1:0] IQTR_RST_DIM = 7'd1;

endpackage : iqtr_pkg

`default_nettype wire

### hw/rtl/image_quarter_turn_rotator_top.sv
// Image quarter-turn rotator: pixel store, address generation and result register.
//
// Usage: write image_width, image_height, quarter_turns and turn_left through
// the cfg_ port while idle, then load the image row-major with op = load (one
// pixel per transfer) and read the turned image row-major with op = fetch.
// busy is always low: one transfer is taken every cycle. A load produces no
// result. A fetch produces exactly one result, shown on the out_ ports with
// out_strobe high for one cycle, on the cycle after the transfer; that delay is
// the registered read port of the pixel memory. The
// receiver cannot stall, so it must take every strobed result. Load and fetch
// keep their own position counters, each wrapping after the last pixel and
// restarting at the origin if a dimension change leaves it outside the image.
// Dimensions of 0 act as 1 and values above the maximum saturate. The pixel
// memory has no reset; fetching a position never loaded returns garbage.
`default_nettype none

module image_quarter_turn_rotator_top
  import iqtr_pkg::*;
#(
  parameter int MAX_WIDTH  = IQTR_MAX_WIDTH,
  parameter int MAX_HEIGHT = IQTR_MAX_HEIGHT,
  parameter int PIXEL_BITS = IQTR_PIXEL_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [IQTR_CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [IQTR_CFG_DATA_W-1:0]        cfg_data,
  // command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_op,
  input  wire logic signed [IQTR_PIX_FLD_W-1:0]  in_pixel,
  // result channel
  output logic                                   out_strobe,
  output logic signed [IQTR_PIX_FLD_W-1:0]       out_pixel,
  output logic [IQTR_POS_FLD_W-1:0]              out_row,
  output logic [IQTR_POS_FLD_W-1:0]              out_col,
  output logic [IQTR_DIM_FLD_W-1:0]              out_width,
  output logic [IQTR_DIM_FLD_W-1:0]              out_height,
  output logic                                   out_last
);

  // Widths derived from the geometry
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW      = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;  // input column
  localparam int RW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;  // input row
  localparam int EW      = (MAX_DIM    > 1) ? $clog2(MAX_DIM)    : 1;  // output row/col
  localparam int DW      = $clog2(MAX_DIM + 1);                         // dimension value
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers (raw values, saturated on use)
  // ---------------------------------------------------------------------------
  logic [IQTR_CFG_DATA_W-1:0] cfg_width_r;
  logic [IQTR_CFG_DATA_W-1:0] cfg_height_r;
  logic [1:0]                 cfg_turns_r;
  logic                       cfg_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= IQTR_RST_DIM;
      cfg_height_r <= IQTR_RST_DIM;
      cfg_turns_r  <= '0;
      cfg_left_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   cfg_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:  cfg_height_r <= cfg_data;
        CFG_QUARTER_TURNS: cfg_turns_r  <= cfg_data[1:0];
        CFG_TURN_LEFT:     cfg_left_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: one transfer per cycle, never stalled
  // ---------------------------------------------------------------------------
  logic accept;
  logic do_load;
  logic do_fetch;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign do_load  = accept && (op_t'(in_op) == OP_LOAD);
  assign do_fetch = accept && (op_t'(in_op) == OP_FETCH);

  // ---------------------------------------------------------------------------
  // Position counters and address generation
  // ---------------------------------------------------------------------------
  logic [CW-1:0] load_col_r, load_col_nxt;
  logic [RW-1:0] load_row_r, load_row_nxt;
  logic [EW-1:0] emit_col_r, emit_col_nxt;
  logic [EW-1:0] emit_row_r, emit_row_nxt;

  logic [DW-1:0] w_dim, h_dim, ow, oh;
  turn_t         turns;
  logic [CW-1:0] lc;
  logic [RW-1:0] lr;
  logic [EW-1:0] ec, er;
  logic [DW-1:0] lc_inc, lr_inc, ec_inc, er_inc;
  logic [DW-1:0] src_row, src_col;
  logic [AW-1:0] load_addr, fetch_addr, mem_addr;

  always_comb begin
    // saturate dimensions into 1..MAX
    if (cfg_width_r == '0)                     w_dim = DW'(1);
    else if (32'(cfg_width_r) > MAX_WIDTH)     w_dim = DW'(MAX_WIDTH);
    else                                       w_dim = DW'(cfg_width_r);
    if (cfg_height_r == '0)                    h_dim = DW'(1);
    else if (32'(cfg_height_r) > MAX_HEIGHT)   h_dim = DW'(MAX_HEIGHT);
    else                                       h_dim = DW'(cfg_height_r);

    // a left turn is a right turn by the complement
    turns = cfg_left_r ? turn_t'(2'd0 - cfg_turns_r) : turn_t'(cfg_turns_r);
    if (turns == TURN_90 || turns == TURN_270) begin
      ow = h_dim;
      oh = w_dim;
    end else begin
      ow = w_dim;
      oh = h_dim;
    end

    // restart a counter that a dimension change left outside the image
    if (DW'(load_row_r) >= h_dim || DW'(load_col_r) >= w_dim) begin
      lr = '0;
      lc = '0;
    end else begin
      lr = load_row_r;
      lc = load_col_r;
    end
    if (DW'(emit_row_r) >= oh || DW'(emit_col_r) >= ow) begin
      er = '0;
      ec = '0;
    end else begin
      er = emit_row_r;
      ec = emit_col_r;
    end

    // source position in the stored image
    unique case (turns)
      TURN_90: begin
        src_row = h_dim - DW'(1) - DW'(ec);
        src_col = DW'(er);
      end
      TURN_180: begin
        src_row = h_dim - DW'(1) - DW'(er);
        src_col = w_dim - DW'(1) - DW'(ec);
      end
      TURN_270: begin
        src_row = DW'(ec);
        src_col = w_dim - DW'(1) - DW'(er);
      end
      default: begin
        src_row = DW'(er);
        src_col = DW'(ec);
      end
    endcase

    load_addr  = AW'(32'(lr) * MAX_WIDTH + 32'(lc));
    fetch_addr = AW'(32'(src_row) * MAX_WIDTH + 32'(src_col));
    mem_addr   = do_load ? load_addr : fetch_addr;

    // advance, row-major with wrap
    lc_inc = DW'(lc) + DW'(1);
    lr_inc = DW'(lr) + DW'(1);
    if (lc_inc >= w_dim) begin
      load_col_nxt = '0;
      load_row_nxt = (lr_inc >= h_dim) ? '0 : RW'(lr_inc);
    end else begin
      load_col_nxt = CW'(lc_inc);
      load_row_nxt = lr;
    end

    ec_inc = DW'(ec) + DW'(1);
    er_inc = DW'(er) + DW'(1);
    if (ec_inc >= ow) begin
      emit_col_nxt = '0;
      emit_row_nxt = (er_inc >= oh) ? '0 : EW'(er_inc);
    end else begin
      emit_col_nxt = EW'(ec_inc);
      emit_row_nxt = er;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_col_r <= '0;
      load_row_r <= '0;
      emit_col_r <= '0;
      emit_row_r <= '0;
    end else begin
      if (do_load) begin
        load_col_r <= load_col_nxt;
        load_row_r <= load_row_nxt;
      end
      if (do_fetch) begin
        emit_col_r <= emit_col_nxt;
        emit_row_r <= emit_row_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel memory: single port, registered read
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] pixel_mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (do_load) begin
      pixel_mem[mem_addr] <= PIXEL_BITS'($unsigned(in_pixel));
    end
    if (do_fetch) begin
      rd_data_r <= pixel_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register, aligned with the memory read
  // ---------------------------------------------------------------------------
  logic                      out_strobe_r;
  logic [IQTR_POS_FLD_W-1:0] out_row_r;
  logic [IQTR_POS_FLD_W-1:0] out_col_r;
  logic [IQTR_DIM_FLD_W-1:0] out_width_r;
  logic [IQTR_DIM_FLD_W-1:0] out_height_r;
  logic                      out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= do_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (do_fetch) begin
      out_row_r    <= IQTR_POS_FLD_W'(er);
      out_col_r    <= IQTR_POS_FLD_W'(ec);
      out_width_r  <= IQTR_DIM_FLD_W'(ow);
      out_height_r <= IQTR_DIM_FLD_W'(oh);
      out_last_r   <= (er_inc == oh) && (ec_inc == ow);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_pixel  = IQTR_PIX_FLD_W'(rd_data_r);
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_width  = out_width_r;
  assign out_height = out_height_r;
  assign out_last   = out_strobe_r && out_last_r;

`ifndef SYNTHESIS
  // a result only follows a fetch transfer
  a_strobe_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rst_n && start && in_op))
    else $error("result strobe without a preceding fetch");

  // a load never produces a result
  a_no_result_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_op) |=> !out_strobe)
    else $error("result strobe after a load");

  // last only marks a strobed result
  a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("last flag without strobe");

  // counters never leave the storage bounds
  a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(load_col_r) < MAX_WIDTH) && (32'(load_row_r) < MAX_HEIGHT) &&
    (32'(emit_col_r) < MAX_DIM) && (32'(emit_row_r) < MAX_DIM))
    else $error("position counter out of range");
`endif

endmodule : image_quarter_turn_rotator_top

`default_nettype wire
